FILE: rtl/circular_buffer_queue_macros.svh
// Assertion macros shared by the circular buffer queue RTL.
`ifndef CIRCULAR_BUFFER_QUEUE_MACROS_SVH
`define CIRCULAR_BUFFER_QUEUE_MACROS_SVH

// Property checked every cycle outside reset.
`define CBQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbq_pkg.sv
// Types and constants shared by the circular buffer queue modules.
`default_nettype none

package cbq_pkg;

    localparam int POS_W = 6;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cbq_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } cbq_status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RDWAIT = 1'b1
    } cbq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic        do_enq;
        logic        do_deq;
        logic        do_rd;
        logic        do_clr;
        logic        ld_now;
        logic        ld_mem;
        cbq_status_t res_status;
    } cbq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic oob;
        logic out_free;
    } cbq_sts_t;

endpackage

`default_nettype wire

FILE: rtl/circular_buffer_queue.sv
// Top level of the circular buffer queue: stream ports, controller and datapath.
//
// Fixed-capacity circular FIFO queue driven by a command stream. Each slave
// transaction carries a command in s_axis_tuser (enqueue, dequeue, read at
// position, clear) and returns exactly one master transaction with the word,
// a status in m_axis_tuser and the element count after the command. Enqueue,
// clear and any rejected command load the result register directly; a dequeue
// or a successful read loads it from the registered read port of the storage RAM.
// A result register on the master side lets the next command be accepted in
// the same cycle the pending result is taken. Storage needs no initialization
// after reset; only locations inside the held count are ever read.
`default_nettype none

module circular_buffer_queue
    import cbq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                                 aclk,
    input  wire logic                                                 aresetn,
    input  wire logic                                                 s_axis_tvalid,
    output logic                                                      s_axis_tready,
    // value, position; zero padded to bytes
    input  wire logic [((DATA_WIDTH+POS_W+7)/8)*8-1:0]                s_axis_tdata,
    // command
    input  wire logic [1:0]                                           s_axis_tuser,
    output logic                                                      m_axis_tvalid,
    input  wire logic                                                 m_axis_tready,
    // data, count; zero padded to bytes
    output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0]           m_axis_tdata,
    // status
    output logic [1:0]                                                m_axis_tuser
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int MTW = ((DATA_WIDTH + CW + 7) / 8) * 8;

    cbq_ctl_t              ctl;
    cbq_sts_t              sts;
    logic [DATA_WIDTH-1:0] m_data;
    cbq_status_t           m_status;
    logic [CW-1:0]         m_count;

    cbq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_cmd   (s_axis_tuser),
        .sts     (sts),
        .ctl     (ctl)
    );

    cbq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sts      (sts),
        .value    (s_axis_tdata[DATA_WIDTH-1:0]),
        .position (s_axis_tdata[DATA_WIDTH+POS_W-1:DATA_WIDTH]),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_data),
        .m_status (m_status),
        .m_count  (m_count)
    );

    assign m_axis_tdata = MTW'({m_count, m_data});
    assign m_axis_tuser = m_status;

endmodule

`default_nettype wire

FILE: rtl/cbq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/cbq_ctrl.sv
// Command decode and sequencing state machine for the circular buffer queue.
`default_nettype none

module cbq_ctrl
    import cbq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire cbq_sts_t   sts,
    output cbq_ctl_t        ctl
);

    cbq_state_t state_reg;
    cbq_state_t state_next;
    cbq_cmd_t   cmd;
    logic       acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctl.do_deq || ctl.do_rd) begin
                    state_next = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd            = cbq_cmd_t'(s_cmd);
        s_ready        = aresetn && (state_reg == S_IDLE) && sts.out_free;
        acc            = s_valid && s_ready;
        ctl            = '0;
        ctl.res_status = ST_OK;
        if (acc) begin
            case (cmd)
                CMD_ENQ: begin
                    if (sts.full) begin
                        ctl.res_status = ST_FULL;
                    end else begin
                        ctl.do_enq = 1'b1;
                    end
                end
                CMD_DEQ: begin
                    if (sts.empty) begin
                        ctl.res_status = ST_EMPTY;
                    end else begin
                        ctl.do_deq = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (sts.empty) begin
                        ctl.res_status = ST_EMPTY;
                    end else if (sts.oob) begin
                        ctl.res_status = ST_RANGE;
                    end else begin
                        ctl.do_rd = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    ctl.do_clr = 1'b1;
                end
                default: begin
                end
            endcase
            ctl.ld_now = !(ctl.do_deq || ctl.do_rd);
        end
        ctl.ld_mem = (state_reg == S_RDWAIT);
    end

endmodule

`default_nettype wire

FILE: rtl/cbq_dp.sv
// Pointers, occupancy, storage RAM and result register of the circular buffer queue.
`default_nettype none
`include "circular_buffer_queue_macros.svh"

module cbq_dp
    import cbq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cbq_ctl_t                     ctl,
    output cbq_sts_t                          sts,
    input  wire logic [DATA_WIDTH-1:0]        value,
    input  wire logic [POS_W-1:0]             position,
    input  wire logic                         m_ready,
    output logic                              m_valid,
    output logic [DATA_WIDTH-1:0]             m_data,
    output cbq_status_t                       m_status,
    output logic [$clog2(DEPTH+1)-1:0]        m_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int OW = (CW > POS_W) ? CW : POS_W;

    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         occ_reg, occ_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] m_data_reg;
    cbq_status_t           m_status_reg;
    logic [CW-1:0]         m_count_reg;

    logic [IW-1:0]         idx_sum;
    logic [IW-1:0]         idx_wrap;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    assign idx_sum  = IW'(head_reg) + IW'(position);
    assign idx_wrap = (idx_sum >= IW'(DEPTH)) ? (idx_sum - IW'(DEPTH)) : idx_sum;
    assign raddr    = ctl.do_rd ? idx_wrap[AW-1:0] : head_reg;

    cbq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.do_enq),
        .waddr (tail_reg),
        .wdata (value),
        .re    (ctl.do_deq || ctl.do_rd),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        sts.empty    = (occ_reg == '0);
        sts.full     = (occ_reg == CW'(DEPTH));
        sts.oob      = (OW'(position) >= OW'(occ_reg));
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (ctl.do_clr) begin
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
        end else if (ctl.do_enq) begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            occ_next  = occ_reg + 1'b1;
        end else if (ctl.do_deq) begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            occ_next  = occ_reg - 1'b1;
        end
    end

    always_comb begin
        if (ctl.ld_now || ctl.ld_mem) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_now) begin
            m_data_reg   <= '0;
            m_status_reg <= ctl.res_status;
            m_count_reg  <= occ_next;
        end else if (ctl.ld_mem) begin
            m_data_reg   <= rdata;
            m_status_reg <= ST_OK;
            m_count_reg  <= occ_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

    `CBQ_ASSERT(a_occ_bound, occ_reg <= CW'(DEPTH), "occupancy above capacity")
    `CBQ_ASSERT(a_err_zero, !m_valid_reg || m_status_reg == ST_OK || m_data_reg == '0, "error result with nonzero data")
    `CBQ_ASSERT(a_mem_slot_free, !ctl.ld_mem || !m_valid_reg, "RAM data returned while result register busy")
    `CBQ_ASSERT_NEXT(a_enq_count, ctl.do_enq, occ_reg == $past(occ_reg) + 1'b1, "enqueue did not bump count")

endmodule

`default_nettype wire
